// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk, with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included
`define ASSERT_CLK_NR(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/u2h_pkg.sv -----
// ----------------------------------------------------------------------------
// u2h_pkg
// Shared types and helpers for the UTF-8 to UCS-2 hex encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u2h_pkg;

  localparam int UNIT_W  = 16;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 2;

  // One decoded code unit, aligned so the first digit sits in the top nibble
  typedef struct packed {
    logic [UNIT_W-1:0]  digits;
    logic [DIGIT_W-1:0] last_idx;  // number of digits minus one
  } unit_t;

  // Lowercase ASCII hex digit for one nibble
  function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = {3'b000, nib};
    if (nib < 4'd10) hex_ascii = 7'h30 + ext;
    else             hex_ascii = 7'h57 + ext;
  endfunction

endpackage

`default_nettype wire

// ----- sv/u2h_decode.sv -----
// ----------------------------------------------------------------------------
// u2h_decode
// UTF-8 sequence tracker: rebuilds code units, sizes them and holds one
// finished unit for the digit serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

module u2h_decode
  import u2h_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            unit_valid,
  output unit_t           unit,
  input  wire logic       unit_take
);

  logic        pad_to_four;
  logic [1:0]  bytes_pending;
  logic [15:0] partial_unit;

  logic [1:0]  bytes_pending_next;
  logic [15:0] partial_unit_next;
  logic        emit;
  logic [15:0] emit_val;
  logic [15:0] joined;
  logic [1:0]  nlast;
  logic        accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !unit_valid || unit_take;
  assign joined   = {partial_unit[9:0], in_byte[5:0]};

  // Byte classification and state update
  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_unit_next  = partial_unit;
    emit               = 1'b0;
    emit_val           = joined;
    if (in_byte == 8'h00) begin
      // end of message drops any open sequence
      bytes_pending_next = 2'd0;
      partial_unit_next  = '0;
    end else if (bytes_pending != 2'd0) begin
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending == 2'd1) begin
        emit              = 1'b1;
        partial_unit_next = '0;
      end else begin
        partial_unit_next = joined;
      end
    end else if (!in_byte[7]) begin
      emit     = 1'b1;
      emit_val = {8'h00, in_byte};
    end else if (in_byte[7:5] == 3'b110) begin
      partial_unit_next  = {11'd0, in_byte[4:0]};
      bytes_pending_next = 2'd1;
    end else if (in_byte[7:4] == 4'b1110) begin
      partial_unit_next  = {12'd0, in_byte[3:0]};
      bytes_pending_next = 2'd2;
    end
    // stray continuation and long lead bytes fall through unchanged
  end

  // Digit count: fixed four, or no leading zeros
  always_comb begin
    priority if (pad_to_four || emit_val[15:12] != 4'h0) nlast = 2'd3;
    else if (emit_val[11:8] != 4'h0)                    nlast = 2'd2;
    else if (emit_val[7:4] != 4'h0)                     nlast = 2'd1;
    else                                                nlast = 2'd0;
  end

  // State, mode register and unit holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_to_four   <= 1'b1;
      bytes_pending <= 2'd0;
      partial_unit  <= '0;
      unit_valid    <= 1'b0;
    end else begin
      if (cfg_we) pad_to_four <= cfg_wdata;
      if (accept) begin
        bytes_pending <= bytes_pending_next;
        partial_unit  <= partial_unit_next;
      end
      if (accept && emit) unit_valid <= 1'b1;
      else if (unit_take) unit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      unit.digits   <= emit_val << {~nlast, 2'b00};
      unit.last_idx <= nlast;
    end
  end

endmodule

`default_nettype wire

// ----- sv/u2h_serial.sv -----
// ----------------------------------------------------------------------------
// u2h_serial
// Digit serialiser: sends one code unit as ASCII hex, one digit per item,
// through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module u2h_serial
  import u2h_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              unit_valid,
  input  wire unit_t             unit,
  output logic                   unit_take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      out_char,
  output logic                   out_last
);

  logic [UNIT_W-1:0]  rest;
  logic [DIGIT_W-1:0] left;
  logic               advance;
  logic               load_ok;

  // Free when empty or when the final digit leaves this cycle
  assign load_ok   = !out_valid || (out_ready && out_last);
  assign unit_take = unit_valid && load_ok;
  assign advance   = out_valid && out_ready && !out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (unit_take) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready && out_last) begin
      out_valid <= 1'b0;
    end
  end

  // Digit shift register and output data
  always_ff @(posedge clk) begin
    if (unit_take) begin
      out_char <= hex_ascii(unit.digits[UNIT_W-1 -: 4]);
      out_last <= (unit.last_idx == '0);
      rest     <= unit.digits << 4;
      left     <= unit.last_idx;
    end else if (advance) begin
      out_char <= hex_ascii(rest[UNIT_W-1 -: 4]);
      out_last <= (left == 2'd1);
      rest     <= rest << 4;
      left     <= left - 2'd1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/utf8_to_ucs2_hex_encoder.sv -----
// ----------------------------------------------------------------------------
// utf8_to_ucs2_hex_encoder
// UTF-8 bytes in, UCS-2 code units out as lowercase ASCII hex digits.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one UTF-8 byte per item; a zero byte ends the message and
//   discards any unfinished sequence. m_axis carries one hex digit per item,
//   most significant first, with tlast on the final digit of each unit.
//   cfg_we/cfg_wdata set pad_to_four (1 after reset): 1 gives four digits per
//   unit, 0 drops leading zeros so that zero gives a single '0'. Write it
//   only while the block is idle.
//   With the serialiser free, a completing byte is first held in the unit
//   register, then its first digit is loaded into the output register.
//   Throughput: one digit per cycle on m_axis while m_axis_tready is high;
//   a unit of n digits is sent as n items; an ASCII byte gives up to four digits.
//   Bytes that complete nothing are taken one per cycle while s_axis_tready is high.
//   A unit register sits between decoder and serialiser, so the next byte is
//   taken while the current unit is still being sent.
//   Reset clears the sequence state, empties both stages and sets padding on.
//   A stall on m_axis holds the digit; s_axis_tready drops once the unit
//   register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_ucs2_hex_encoder
  import u2h_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,      // pad_to_four
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [6:0] hex_char, [7] zero
  output logic            m_axis_tlast    // last_digit
);

  logic              unit_valid;
  logic              unit_take;
  unit_t             unit;
  logic [CHAR_W-1:0] hex_char;

  u2h_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .unit_valid (unit_valid),
    .unit       (unit),
    .unit_take  (unit_take)
  );

  u2h_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit       (unit),
    .unit_take  (unit_take),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_char   (hex_char),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, hex_char};

endmodule

`default_nettype wire

// ----- sv/u2h_checker.sv -----
// ----------------------------------------------------------------------------
// u2h_checker
// Port-level checks for the UTF-8 to UCS-2 hex encoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module u2h_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // A stalled digit holds
  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output digit changed under stall")

  // Only lowercase hex characters leave the block
  `ASSERT_CLK(a_hex_range, m_axis_tvalid |-> (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) || (m_axis_tdata >= 8'h61 && m_axis_tdata <= 8'h66), "output is not a hex digit")

  // Input back-pressure only while the output stage holds a digit
  `ASSERT_CLK(a_ready_cause, !s_axis_tready |-> m_axis_tvalid, "input stalled with empty output")

  // Reset empties the output stage
  `ASSERT_CLK_NR(a_reset_empty, rst |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind utf8_to_ucs2_hex_encoder u2h_checker u_u2h_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
